FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LRFG_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrfg check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LRFG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrfg check failed");

`endif

FILE: src/lrfg_pkg.sv
// Types, constants and the color wheel of the rainbow frame generator.
package lrfg_pkg;

	localparam int PIXELS_DEFAULT = 8;
	localparam int QUEUE_DEPTH    = 2;
	localparam int IDX_W          = 6;
	localparam int COLOR_W        = 8;
	localparam int WAIT_W         = 8;
	localparam int TICK_W         = 9;

	localparam logic [TICK_W-1:0]  TICK_MAX         = 9'd511;
	localparam logic [WAIT_W-1:0]  WAIT_PLAIN_RESET = 8'd5;
	localparam logic [WAIT_W-1:0]  WAIT_CYCLE_RESET = 8'd2;

	localparam logic [COLOR_W-1:0] SEG_1      = 8'd85;
	localparam logic [COLOR_W-1:0] SEG_2      = 8'd170;
	localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

	typedef enum logic {
		REG_WAIT_PLAIN = 1'b0,
		REG_WAIT_CYCLE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic               cycle;
		logic [COLOR_W-1:0] phase;
	} frame_cmd_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
	} color_t;

	// Three-segment wheel, each segment a linear ramp of slope three.
	function automatic color_t wheel(input logic [COLOR_W-1:0] pos);
		logic [COLOR_W-1:0] p;
		logic [COLOR_W-1:0] q;
		logic [COLOR_W+1:0] tq;
		color_t             c;
		p = ~pos;
		if (p < SEG_1) begin
			q = p;
		end else if (p < SEG_2) begin
			q = p - SEG_1;
		end else begin
			q = p - SEG_2;
		end
		tq = {2'b00, q} + {1'b0, q, 1'b0};
		if (p < SEG_1) begin
			c.red   = COLOR_FULL - tq[COLOR_W-1:0];
			c.green = '0;
			c.blue  = tq[COLOR_W-1:0];
		end else if (p < SEG_2) begin
			c.red   = '0;
			c.green = tq[COLOR_W-1:0];
			c.blue  = COLOR_FULL - tq[COLOR_W-1:0];
		end else begin
			c.red   = tq[COLOR_W-1:0];
			c.green = COLOR_FULL - tq[COLOR_W-1:0];
			c.blue  = '0;
		end
		return c;
	endfunction

endpackage

FILE: src/lrfg_front.sv
// Tick front end: counts ticks, steps the selected phase and issues frame commands.
module lrfg_front
	import lrfg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick_valid,
	output logic               tick_ready,
	input  logic               cycle_mode,
	input  logic [WAIT_W-1:0]  wait_plain,
	input  logic [WAIT_W-1:0]  wait_cycle,
	input  logic               queue_full,
	output logic               push,
	output frame_cmd_t         push_cmd
);

	logic [TICK_W-1:0]  elapsed_q;
	logic [COLOR_W-1:0] phase_plain_q;
	logic [COLOR_W-1:0] phase_cycle_q;
	logic [TICK_W-1:0]  elapsed_inc;
	logic [WAIT_W-1:0]  wait_sel;
	logic               tick_take;
	logic               step;

	assign tick_ready  = !queue_full;
	assign tick_take   = tick_valid && tick_ready;
	assign elapsed_inc = (elapsed_q < TICK_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign wait_sel    = cycle_mode ? wait_cycle : wait_plain;
	assign step        = elapsed_inc > {1'b0, wait_sel};

	assign push           = tick_take && step;
	assign push_cmd.cycle = cycle_mode;
	assign push_cmd.phase = cycle_mode ? phase_cycle_q + 1'b1 : phase_plain_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q     <= '0;
			phase_plain_q <= '0;
			phase_cycle_q <= '0;
		end else if (tick_take) begin
			if (step) begin
				elapsed_q <= '0;
				if (cycle_mode) begin
					phase_cycle_q <= push_cmd.phase;
				end else begin
					phase_plain_q <= push_cmd.phase;
				end
			end else begin
				elapsed_q <= elapsed_inc;
			end
		end
	end

endmodule

FILE: src/lrfg_queue.sv
// Short command queue between the tick front end and the pixel back end.
module lrfg_queue
	import lrfg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output logic       pop_valid,
	output frame_cmd_t pop_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	frame_cmd_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/lrfg_back.sv
// Pixel back end: walks the pixels of a frame and registers one color per beat.
module lrfg_back
	import lrfg_pkg::*;
#(
	parameter int PIXELS = PIXELS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  frame_cmd_t         cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   pixel_index,
	output color_t             color,
	output logic               frame_last
);

	// The cycle-mode offset i*256/PIXELS advances by a fixed quotient and remainder.
	localparam int Q_STEP = 256 / PIXELS;
	localparam int R_STEP = 256 % PIXELS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

	logic               busy_q;
	logic               cyc_q;
	logic [COLOR_W-1:0] phase_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COLOR_W-1:0] quot_q;
	logic [IDX_W-1:0]   rem_q;
	logic               out_valid_q;

	logic [COLOR_W-1:0] pos;
	logic               last;
	logic               emit;
	logic               load;
	logic [IDX_W:0]     rem_sum;
	logic               rem_wrap;
	logic [IDX_W:0]     rem_next;

	assign pos  = cyc_q ? quot_q + phase_q : {{(COLOR_W-IDX_W){1'b0}}, idx_q} + phase_q;
	assign last = idx_q == LAST_IDX;
	assign emit = busy_q && (!out_valid_q || out_ready);
	assign load = cmd_valid && (!busy_q || (emit && last));

	assign rem_sum  = {1'b0, rem_q} + (IDX_W+1)'(R_STEP);
	assign rem_wrap = rem_sum >= (IDX_W+1)'(PIXELS);
	assign rem_next = rem_wrap ? rem_sum - (IDX_W+1)'(PIXELS) : rem_sum;

	assign cmd_pop   = load;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cyc_q   <= cmd.cycle;
			phase_q <= cmd.phase;
			idx_q   <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
		end else if (emit) begin
			idx_q  <= idx_q + 1'b1;
			quot_q <= quot_q + COLOR_W'(Q_STEP) + {{(COLOR_W-1){1'b0}}, rem_wrap};
			rem_q  <= rem_next[IDX_W-1:0];
		end
		if (emit) begin
			pixel_index <= idx_q;
			color       <= wheel(pos);
			frame_last  <= last;
		end
	end

endmodule

FILE: src/led_rainbow_frame_generator.sv
// Top level of the LED rainbow frame generator: register port, front end, queue and back end.
// Each beat on s_axis is one millisecond tick; s_tdata bit 0 selects plain rainbow (0) or
// rainbow cycle (1). A tick is taken whenever the two-entry frame queue has room, so ticks
// may arrive back to back. A tick that steps its mode's phase queues one frame, which leaves
// m_axis as PIXELS beats at one beat per cycle while m_tready is high; the pixel sequencer
// of the back end sets that rate. Each frame passes through the queue and the back end's
// output register. A tick that does not step produces no beat. Registers: wait_plain at
// address 0 and wait_cycle at address 4; write them only while no frame is in flight.
module led_rainbow_frame_generator
	import lrfg_pkg::*;
#(
	parameter int PIXELS = PIXELS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] cycle_mode, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [5:0] pixel_index, [13:6] green, [21:14] red,
	                               // [29:22] blue, [31:30] zero
	output logic        m_tlast,   // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [WAIT_W-1:0] wait_plain_q;
	logic [WAIT_W-1:0] wait_cycle_q;
	reg_index_t        reg_sel;
	logic              cfg_write;

	logic              queue_full;
	logic              push;
	frame_cmd_t        push_cmd;
	logic              pop;
	logic              pop_valid;
	frame_cmd_t        pop_cmd;
	logic [IDX_W-1:0]  pixel_index;
	color_t            color;

	assign pready    = 1'b1;
	assign reg_sel   = reg_index_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_WAIT_PLAIN: prdata = {{(32-WAIT_W){1'b0}}, wait_plain_q};
			REG_WAIT_CYCLE: prdata = {{(32-WAIT_W){1'b0}}, wait_cycle_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_plain_q <= WAIT_PLAIN_RESET;
			wait_cycle_q <= WAIT_CYCLE_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_WAIT_PLAIN: wait_plain_q <= pwdata[WAIT_W-1:0];
				REG_WAIT_CYCLE: wait_cycle_q <= pwdata[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	lrfg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (s_tvalid),
		.tick_ready (s_tready),
		.cycle_mode (s_tdata[0]),
		.wait_plain (wait_plain_q),
		.wait_cycle (wait_cycle_q),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lrfg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	lrfg_back #(
		.PIXELS (PIXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (pop_valid),
		.cmd         (pop_cmd),
		.cmd_pop     (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.pixel_index (pixel_index),
		.color       (color),
		.frame_last  (m_tlast)
	);

	assign m_tdata = {2'b00, color.blue, color.red, color.green, pixel_index};

endmodule

FILE: src/lrfg_checker.sv
// Port-level checks of the rainbow frame generator and their binding to the top level.
`include "assert_macros.svh"

module lrfg_checker #(
	parameter int PIXELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast
);

	localparam logic [5:0] LAST_IDX = 6'(PIXELS - 1);

	logic [5:0] pixel;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] blue;
	logic [9:0] color_sum;
	logic       one_zero;
	logic       color_ok;

	assign pixel     = m_tdata[5:0];
	assign green     = m_tdata[13:6];
	assign red       = m_tdata[21:14];
	assign blue      = m_tdata[29:22];
	assign color_sum = {2'b00, green} + {2'b00, red} + {2'b00, blue};
	assign one_zero  = (green == 8'd0) || (red == 8'd0) || (blue == 8'd0);
	// Every wheel color splits full scale between two channels and leaves the third dark.
	assign color_ok  = one_zero && (color_sum == 10'd255) && (m_tdata[31:30] == 2'b00);

	`LRFG_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	`LRFG_ASSERT(a_last_index, m_tvalid && m_tlast, pixel == LAST_IDX)
	`LRFG_ASSERT(a_inner_index, m_tvalid && !m_tlast, pixel < LAST_IDX)
	`LRFG_ASSERT(a_color, m_tvalid, color_ok)

endmodule

bind led_rainbow_frame_generator lrfg_checker #(
	.PIXELS (PIXELS)
) u_lrfg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: sim/tb_top.sv
// Self-checking testbench of the LED rainbow frame generator: tick stimulus, pixel prediction, APB setup.
module tb_top;
	import lrfg_pkg::*;

	localparam int NUM_PIXELS   = PIXELS_DEFAULT;
	localparam int FRAME_LEN    = (NUM_PIXELS > 64) ? 64 : NUM_PIXELS;
	localparam int DRAIN_CYCLES = 8;
	localparam bit PLAIN        = 1'b0;
	localparam bit CYCLE        = 1'b1;

	typedef struct {
		logic [5:0] index;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [0] cycle_mode, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [5:0] pixel_index, [13:6] green, [21:14] red, [29:22] blue
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Mirror of the block's state and registers.
	logic [TICK_W-1:0] tick_count  = '0;
	logic [7:0]        phase_plain = '0;
	logic [7:0]        phase_cycle = '0;
	logic [7:0]        wait_plain  = WAIT_PLAIN_RESET;
	logic [7:0]        wait_cycle  = WAIT_CYCLE_RESET;

	bit     tick_mode_q[$];
	pixel_t pixel_expect_q[$];
	int     error_count    = 0;
	int     send_idle_pct  = 0;
	int     recv_stall_pct = 0;

	led_rainbow_frame_generator #(.PIXELS(NUM_PIXELS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		if (error_count <= 40)
			$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic pixel_t wheel_pixel(input logic [7:0] pos, input int index);
		int     p;
		pixel_t px;
		p = 255 - int'(pos);
		px.index = index[5:0];
		px.last  = (index == FRAME_LEN - 1);
		if (p < 85) begin
			px.red   = 8'(255 - 3 * p);
			px.green = 8'd0;
			px.blue  = 8'(3 * p);
		end else if (p < 170) begin
			p = p - 85;
			px.red   = 8'd0;
			px.green = 8'(3 * p);
			px.blue  = 8'(255 - 3 * p);
		end else begin
			p = p - 170;
			px.red   = 8'(3 * p);
			px.green = 8'(255 - 3 * p);
			px.blue  = 8'd0;
		end
		return px;
	endfunction

	// One tick: count it, and if the selected wait is exceeded step that phase and queue a frame.
	task automatic predict_tick(input bit cycle);
		logic [7:0] wait_ticks;
		logic [7:0] phase;
		int         pos;
		wait_ticks = cycle ? wait_cycle : wait_plain;
		if (tick_count < TICK_MAX)
			tick_count++;
		if (tick_count <= {1'b0, wait_ticks})
			return;
		tick_count = '0;
		if (cycle) begin
			phase_cycle++;
			phase = phase_cycle;
		end else begin
			phase_plain++;
			phase = phase_plain;
		end
		for (int i = 0; i < FRAME_LEN; i++) begin
			pos = cycle ? (i * 256 / NUM_PIXELS + int'(phase)) : (i + int'(phase));
			pixel_expect_q.push_back(wheel_pixel(8'(pos), i));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : tick_driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_tick(s_tdata[0]);
			if (!s_tvalid || s_tready) begin
				if (tick_mode_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, tick_mode_q.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : pixel_monitor
		pixel_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pixel_expect_q.size() == 0) begin
					report_mismatch("unexpected pixel beat, index", m_tdata[5:0], -1);
				end else begin
					want = pixel_expect_q.pop_front();
					if (m_tdata[5:0] != want.index)
						report_mismatch("pixel_index", m_tdata[5:0], want.index);
					if (m_tdata[13:6] != want.green)
						report_mismatch("green", m_tdata[13:6], want.green);
					if (m_tdata[21:14] != want.red)
						report_mismatch("red", m_tdata[21:14], want.red);
					if (m_tdata[29:22] != want.blue)
						report_mismatch("blue", m_tdata[29:22], want.blue);
					if (m_tlast != want.last)
						report_mismatch("frame_last", m_tlast, want.last);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic apb_access(input reg_index_t r, input bit write, input logic [31:0] data,
			output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {r, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_wait_reg(input reg_index_t r, input logic [7:0] want);
		logic [31:0] rd;
		apb_access(r, 1'b0, '0, rd);
		if (rd[7:0] != want)
			report_mismatch(r == REG_WAIT_PLAIN ? "wait_plain readback" : "wait_cycle readback",
				rd[7:0], want);
	endtask

	// The upper bits of the write data are random; only the low byte may take effect.
	task automatic program_wait(input reg_index_t r, input logic [7:0] value);
		logic [31:0] data;
		logic [31:0] rd;
		data = $urandom;
		data[7:0] = value;
		apb_access(r, 1'b1, data, rd);
		if (r == REG_WAIT_PLAIN)
			wait_plain = value;
		else
			wait_cycle = value;
		check_wait_reg(r, value);
	endtask

	task automatic queue_run(input bit mode, input int len);
		repeat (len) tick_mode_q.push_back(mode);
	endtask

	// Runs of one mode with random lengths, so that waits longer than one tick can expire.
	task automatic queue_random_ticks(input int n);
		int added;
		int len;
		bit mode;
		added = 0;
		while (added < n) begin
			mode = 1'($urandom_range(1));
			len  = $urandom_range(1, 8);
			if (len > n - added)
				len = n - added;
			queue_run(mode, len);
			added += len;
		end
	endtask

	// Holds the test sequence until every queued tick is taken and every pixel has come back.
	task automatic wait_idle();
		do @(negedge clk);
		while (tick_mode_q.size() != 0 || s_tvalid || pixel_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] wp, input logic [7:0] wc, input int sidle,
			input int rstall, input int n);
		program_wait(REG_WAIT_PLAIN, wp);
		program_wait(REG_WAIT_CYCLE, wc);
		@(negedge clk);
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		queue_random_ticks(n);
		wait_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		check_wait_reg(REG_WAIT_PLAIN, WAIT_PLAIN_RESET);
		check_wait_reg(REG_WAIT_CYCLE, WAIT_CYCLE_RESET);

		// Reset waits; a mode switch in the middle of a count shares the tick counter.
		@(negedge clk);
		queue_run(PLAIN, 6);
		queue_run(CYCLE, 3);
		queue_run(PLAIN, 2);
		queue_run(CYCLE, 1);
		wait_idle();

		// A zero wait steps on every tick; the longest wait holds the other mode back.
		program_wait(REG_WAIT_PLAIN, 8'd0);
		program_wait(REG_WAIT_CYCLE, 8'd255);
		@(negedge clk);
		queue_run(PLAIN, 4);
		queue_run(CYCLE, 2);
		queue_run(PLAIN, 1);
		queue_run(CYCLE, 2);
		wait_idle();

		run_phase(8'd0, 8'd0, 0, 0, 40);
		run_phase(8'($urandom_range(3)), 8'($urandom_range(3)), 64, 0, 40);
		run_phase(8'd1, 8'($urandom_range(2, 6)), 0, 64, 40);
		run_phase(8'($urandom_range(7)), 8'd0, 23, 23, 40);
		run_phase(8'($urandom_range(15)), 8'($urandom_range(15)), 23, 23, 40);

		if (error_count == 0)
			$display("[led_rainbow_frame_generator] OK");
		else
			$display("[led_rainbow_frame_generator] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[led_rainbow_frame_generator] ERROR");
		$finish;
	end

endmodule
